/* sv/omkt_pkg.sv */
// shared types, codes and defaults for the ordered multimap key table
package omkt_pkg;

   // fixed field widths
   localparam int OP_W      = 3;
   localparam int KEY_W     = 64;
   localparam int DATA_W    = 64;
   localparam int START_W   = 7;
   localparam int HIT_IDX_W = 6;
   localparam int COUNT_W   = 7;

   // parameter defaults
   localparam int TABLE_DEPTH_DEFAULT = 64;
   localparam int VALUE_WIDTH_DEFAULT = 64;

   // operation codes
   localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
   localparam logic [OP_W-1:0] OP_SET    = 3'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
   localparam logic [OP_W-1:0] OP_RESET  = 3'd4;

   // request transaction
   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [KEY_W-1:0]   key_digest;
      logic [DATA_W-1:0]  entry_value;
      logic [START_W-1:0] start_index;
   } req_type;

   // response transaction
   typedef struct packed {
      logic                 found;
      logic [HIT_IDX_W-1:0] hit_index;
      logic [DATA_W-1:0]    hit_value;
      logic [COUNT_W-1:0]   purged_count;
      logic [COUNT_W-1:0]   entry_count;
      logic                 full_drop;
   } rsp_type;

   // classified command kinds
   typedef enum logic [2:0] {
      CMD_ADD,
      CMD_SET,
      CMD_LOOKUP,
      CMD_REMOVE,
      CMD_RESET,
      CMD_NOP
   } cmd_kind_type;

   // command handed from front end to back end
   typedef struct packed {
      cmd_kind_type       kind;
      logic [KEY_W-1:0]   key_digest;
      logic [DATA_W-1:0]  entry_value;
      logic [START_W-1:0] start_index;
   } cmd_type;

endpackage

/* sv/omkt_ram.sv */
// generic single write, single read ram with registered read data
module omkt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/omkt_front.sv */
// front end: accepts requests, classifies them and queues commands
module omkt_front import omkt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_pop
);

   cmd_type    entry_ff [2];
   logic       head_ff, head_in;
   logic       tail_ff, tail_in;
   logic [1:0] count_ff, count_in;
   cmd_type    decoded;
   logic       push;

   // classify the operation code
   always_comb begin
      decoded.key_digest  = req_data.key_digest;
      decoded.entry_value = req_data.entry_value;
      decoded.start_index = req_data.start_index;
      unique case (req_data.operation)
         OP_ADD:    decoded.kind = CMD_ADD;
         OP_SET:    decoded.kind = CMD_SET;
         OP_LOOKUP: decoded.kind = CMD_LOOKUP;
         OP_REMOVE: decoded.kind = CMD_REMOVE;
         OP_RESET:  decoded.kind = CMD_RESET;
         default:   decoded.kind = CMD_NOP;
      endcase
   end

   // two entry command queue
   assign busy      = (count_ff == 2'd2);
   assign push      = start && !busy;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = entry_ff[head_ff];

   always_comb begin
      head_in  = cmd_pop ? !head_ff : head_ff;
      tail_in  = push ? !tail_ff : tail_ff;
      count_in = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= decoded;
      end
      if (reset) begin
         head_ff  <= 1'b0;
         tail_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

/* sv/omkt_back.sv */
// back end: walks the table for lookup, compaction and append
module omkt_back import omkt_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > START_W) ? CNT_W : START_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPEND
   } state_type;

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic [CNT_W-1:0] gone_ff, gone_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   // ram ports
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic [KEY_W-1:0]       rd_key;
   logic [VALUE_WIDTH-1:0] rd_value;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [KEY_W-1:0]       wr_key;
   logic [VALUE_WIDTH-1:0] wr_value;

   logic [CMP_W-1:0] start_ext;
   logic [CMP_W-1:0] fill_ext;
   logic             issue_ok;
   logic             match;
   logic [CNT_W-1:0] fill_left;

   omkt_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_key),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_key)
   );

   omkt_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(TABLE_DEPTH)) u_value_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_value)
   );

   // scan helpers
   assign start_ext = CMP_W'(cmd.start_index);
   assign fill_ext  = CMP_W'(fill_ff);
   assign issue_ok  = (issue_ff < fill_ff);
   assign match     = (rd_key == cmd_ff.key_digest);
   assign fill_left = fill_ff - gone_ff;
   assign rd_addr   = issue_ff[IDX_W-1:0];

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      fill_in      = fill_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      gone_in      = gone_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = pend_idx_ff - gone_ff[IDX_W-1:0];
      wr_key       = rd_key;
      wr_value     = rd_value;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               gone_in = '0;
               pend_in = 1'b0;
               rsp_in  = '0;
               rsp_in.entry_count = COUNT_W'(fill_ff);
               unique case (cmd.kind)
                  CMD_ADD: begin
                     state_in = ST_APPEND;
                  end
                  CMD_SET, CMD_REMOVE: begin
                     issue_in = '0;
                     state_in = ST_SCAN;
                  end
                  CMD_LOOKUP: begin
                     if (start_ext >= fill_ext) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        issue_in = start_ext[CNT_W-1:0];
                        state_in = ST_SCAN;
                     end
                  end
                  CMD_RESET: begin
                     fill_in            = '0;
                     rsp_in.entry_count = '0;
                     rsp_valid_in       = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // issue the next read one entry ahead of the compare
            if (issue_ok) begin
               rd_en       = 1'b1;
               issue_in    = issue_ff + 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[IDX_W-1:0];
            end else begin
               pend_in = 1'b0;
            end
            if (cmd_ff.kind == CMD_LOOKUP) begin
               // first match ends the lookup
               if (pend_ff && match) begin
                  rsp_in.found     = 1'b1;
                  rsp_in.hit_index = HIT_IDX_W'(pend_idx_ff);
                  rsp_in.hit_value = DATA_W'(rd_value);
                  rsp_valid_in     = 1'b1;
                  pend_in          = 1'b0;
                  state_in         = ST_IDLE;
               end else if (!pend_ff && !issue_ok) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               // drop matches, shift survivors down over the gap
               if (pend_ff) begin
                  if (match) begin
                     gone_in = gone_ff + 1'b1;
                  end else if (gone_ff != '0) begin
                     wr_en = 1'b1;
                  end
               end
               if (!pend_ff && !issue_ok) begin
                  fill_in = fill_left;
                  if (cmd_ff.kind == CMD_SET) begin
                     state_in = ST_APPEND;
                  end else begin
                     rsp_in.purged_count = COUNT_W'(gone_ff);
                     rsp_in.entry_count  = COUNT_W'(fill_left);
                     rsp_valid_in        = 1'b1;
                     state_in            = ST_IDLE;
                  end
               end
            end
         end

         ST_APPEND: begin
            rsp_in.purged_count = COUNT_W'(gone_ff);
            if (fill_ff >= CNT_W'(TABLE_DEPTH)) begin
               rsp_in.full_drop   = 1'b1;
               rsp_in.entry_count = COUNT_W'(fill_ff);
            end else begin
               wr_en              = 1'b1;
               wr_addr            = fill_ff[IDX_W-1:0];
               wr_key             = cmd_ff.key_digest;
               wr_value           = cmd_ff.entry_value[VALUE_WIDTH-1:0];
               fill_in            = fill_ff + 1'b1;
               rsp_in.entry_count = COUNT_W'(fill_ff + 1'b1);
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered response
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      issue_ff    <= issue_in;
      pend_idx_ff <= pend_idx_in;
      gone_ff     <= gone_in;
      rsp_ff      <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

/* sv/ordered_multimap_key_table.sv */
// Ordered multimap key table: an insertion-ordered table of (key hash, value) pairs with
// duplicates. A request is taken when start is high and busy is low; a two-entry command
// queue lets requests arrive while the back end works, and busy rises only when that queue
// is full. Each request yields exactly one response, shown for one cycle under rsp_strobe
// in the cycle after the back end finishes the command; the receiver cannot stall it. The
// back end walks the table one entry per cycle through the read port of the key/value RAMs:
// a remove scans every entry held and compacts the survivors, a set does the same and then
// appends, a lookup scans from start_index up to the first match or the end, an add appends
// unless the table is full, and reset, unknown codes and a lookup that starts past the end
// answer straight from idle. The back end finishes one command before it takes the next
// from the queue. No clearing pass follows reset.
module ordered_multimap_key_table import omkt_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   // accept and classify
   omkt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // execute against the table
   omkt_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
